FILE: sv/lja_pkg.sv
// Shared constants for the LCG jump-ahead block.
`timescale 1ns / 1ps
package lja_pkg;

	// Generator word and square-and-multiply pass count
	localparam int unsigned WORD_W = 32;
	localparam int unsigned ITER_N = 32;
	localparam int unsigned ITER_W = 5;

	// Forward rule x*FWD_MULT + FWD_ADD and its inverse multiplier
	localparam logic [WORD_W-1:0] FWD_MULT = 32'd214013;
	localparam logic [WORD_W-1:0] FWD_ADD  = 32'd2531011;
	localparam logic [WORD_W-1:0] INV_MULT = 32'd3115528533;

	// Addend of the inverse map: (0 - FWD_ADD) * INV_MULT mod 2^32
	localparam logic [63:0] INV_ADD_FULL =
		64'(32'd0 - FWD_ADD) * 64'(INV_MULT);
	localparam logic [WORD_W-1:0] INV_ADD = INV_ADD_FULL[WORD_W-1:0];

	// Float pattern of 1.0, trimmed to the 30-bit result field
	localparam logic [29:0] ONE_BITS = 30'h3f800000;

endpackage

FILE: sv/lja_mul.sv
// Digit-serial multiply-add unit: prod = x*y + c mod 2^32.
`timescale 1ns / 1ps
module lja_mul import lja_pkg::*; #(
	parameter int unsigned DIGIT_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [WORD_W-1:0] x,
	input  logic [WORD_W-1:0] y,
	input  logic [WORD_W-1:0] c,
	output logic [WORD_W-1:0] prod
);

	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] pp;

	// Partial product of the shifted multiplicand and the lowest digit of y
	assign pp = x_q * WORD_W'(y_q[DIGIT_W-1:0]);

	// Load operands, then add one digit's partial product per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			acc_q <= '0;
		end else if (load) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= c;
		end else begin
			x_q   <= x_q << DIGIT_W;
			y_q   <= y_q >> DIGIT_W;
			acc_q <= acc_q + pp;
		end
	end

	assign prod = acc_q;

endmodule

FILE: sv/lja_jump_ahead_dummy_guard.sv
// Step-count sign handling: magnitude and direction constants for the jump.
`timescale 1ns / 1ps
module lja_dir import lja_pkg::*; (
	input  logic signed [WORD_W-1:0] step_count,
	output logic        [WORD_W-1:0] mag,
	output logic        [WORD_W-1:0] base_mult,
	output logic        [WORD_W-1:0] base_add
);

	logic [WORD_W-1:0] sc_u;

	// Backward counts use the inverse map over the negated count
	assign sc_u      = step_count;
	assign mag       = sc_u[WORD_W-1] ? (WORD_W'(0) - sc_u) : sc_u;
	assign base_mult = sc_u[WORD_W-1] ? INV_MULT : FWD_MULT;
	assign base_add  = sc_u[WORD_W-1] ? INV_ADD : FWD_ADD;

endmodule

FILE: sv/lcg_jump_ahead.sv
// Top level of the LCG jump-ahead block: sequencer and affine-map registers.
`timescale 1ns / 1ps
//
// Moves a 32-bit state of x' = x*214013 + 2531011 (mod 2^32) by a signed
// step count, backwards through the inverse map for negative counts.
// Command channel: an item (seed, step_count) is taken at a rising edge with
// start high and busy low. busy stays high until the result goes out.
// Result channel: new_state and float_bits sit on the ports for exactly one
// cycle with done high; the receiver must take them then, it cannot stall.
// Sequence: 32 square-and-multiply passes, one step-count bit each, then one
// final multiply-add with the seed. Every pass loads four digit-serial
// multipliers, runs them in the multiply state and updates the map; the
// final multiply-add loads, multiplies and goes to the output state, after
// which done rises. The multiplier digit width sets the multiply length.
// One item is in flight at a time; busy falls on the cycle done is shown,
// so the next item can be taken then.
// Reset clears the sequencer and the strobe; no item survives reset.
//
module lcg_jump_ahead import lja_pkg::*; #(
	parameter int unsigned DIGIT_W = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic        [WORD_W-1:0] seed,
	input  logic signed [WORD_W-1:0] step_count,
	output logic                     done,
	output logic        [WORD_W-1:0] new_state,
	output logic        [29:0]       float_bits
);

	localparam int unsigned DIG_N = WORD_W / DIGIT_W;
	localparam int unsigned CNT_W = $clog2(DIG_N);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ITER_W-1:0] iter_q;
	logic              fin_q;
	logic              done_q;
	logic [WORD_W-1:0] a_q, b_q, mult_q, add_q, n_q, seed_q;
	logic [WORD_W-1:0] new_state_q;
	logic [29:0]       float_bits_q;

	logic [WORD_W-1:0] mag, base_mult, base_add;
	logic [WORD_W-1:0] p_add, p_mult, p_b, p_a;
	logic [WORD_W-1:0] x_add, y_add, c_add;
	logic              load;
	logic              accept;

	assign accept = start && !busy;
	assign load   = (state_q == ST_LOAD);

	lja_dir u_dir (
		.step_count (step_count),
		.mag        (mag),
		.base_mult  (base_mult),
		.base_add   (base_add)
	);

	// Shared unit: add' = a*add + b during passes, seed*mult + add at the end
	assign x_add = fin_q ? mult_q : a_q;
	assign y_add = fin_q ? seed_q : add_q;
	assign c_add = fin_q ? add_q  : b_q;

	lja_mul #(.DIGIT_W(DIGIT_W)) u_mul_add (
		.clk(clk), .arst_n(arst_n), .load(load),
		.x(x_add), .y(y_add), .c(c_add), .prod(p_add)
	);

	lja_mul #(.DIGIT_W(DIGIT_W)) u_mul_mult (
		.clk(clk), .arst_n(arst_n), .load(load),
		.x(a_q), .y(mult_q), .c('0), .prod(p_mult)
	);

	lja_mul #(.DIGIT_W(DIGIT_W)) u_mul_b (
		.clk(clk), .arst_n(arst_n), .load(load),
		.x(a_q), .y(b_q), .c(b_q), .prod(p_b)
	);

	lja_mul #(.DIGIT_W(DIGIT_W)) u_mul_a (
		.clk(clk), .arst_n(arst_n), .load(load),
		.x(a_q), .y(a_q), .c('0), .prod(p_a)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iter_q  <= '0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
						iter_q  <= '0;
						fin_q   <= 1'b0;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
					cnt_q   <= CNT_W'(DIG_N - 1);
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= fin_q ? ST_OUT : ST_UPD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_UPD: begin
					state_q <= ST_LOAD;
					iter_q  <= iter_q + 1'b1;
					if (iter_q == ITER_W'(ITER_N - 1)) begin
						fin_q <= 1'b1;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Affine-map registers: square every pass, fold in when the bit is set
	always_ff @(posedge clk) begin
		if (accept) begin
			seed_q <= seed;
			n_q    <= mag;
			a_q    <= base_mult;
			b_q    <= base_add;
			mult_q <= WORD_W'(1);
			add_q  <= '0;
		end else if (state_q == ST_UPD) begin
			a_q <= p_a;
			b_q <= p_b;
			n_q <= n_q >> 1;
			if (n_q[0]) begin
				mult_q <= p_mult;
				add_q  <= p_add;
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			new_state_q  <= p_add;
			float_bits_q <= ONE_BITS | {7'd0, p_add[30:16], 8'd0};
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign new_state  = new_state_q;
	assign float_bits = float_bits_q;

	// Checks
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_OUT))
		else $error("result strobe without final multiply");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD) && !fin_q)
		else $error("accepted item did not start a pass");

	a_final_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> fin_q && (iter_q == '0))
		else $error("final multiply before all passes");

	a_float_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (float_bits[29:23] == ONE_BITS[29:23]) && (float_bits[7:0] == 8'd0))
		else $error("float pattern outside [1,2)");

endmodule

FILE: dv/lja_leap_checker.sv
// Checker for the LCG jump-ahead block: predicts each jump and compares the results.
`timescale 1ns / 1ps
module lja_leap_checker import lja_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic        [WORD_W-1:0] seed,
	input  logic signed [WORD_W-1:0] step_count,
	input  logic                     done,
	input  logic        [WORD_W-1:0] new_state,
	input  logic        [29:0]       float_bits,
	output int                       mismatch_cnt,
	output int                       leaps_pending,
	output int                       jumps_taken,
	output int                       backward_jumps,
	output int                       zero_jumps,
	output int                       results_checked
);

	// Generator x*A + C and the inverse multiplier of A mod 2^32
	localparam logic [31:0] LCG_A     = 32'd214013;
	localparam logic [31:0] LCG_C     = 32'd2531011;
	localparam logic [31:0] LCG_A_INV = 32'd3115528533;
	localparam logic [29:0] ONE_PATTERN = 30'h3f800000;
	localparam logic [29:0] MANT_FIELD  = 30'h007fff00;

	typedef struct packed {
		logic [31:0] state;
		logic [29:0] fbits;
	} leap_result_t;

	leap_result_t pending_leaps[$];

	// State after n steps: compose the affine map by square-and-multiply,
	// stepping through the inverse map when the count is negative
	function automatic leap_result_t lcg_leap(input logic [31:0] s, input logic [31:0] n_bits);
		logic [31:0] m, c, mult, add, n, ns;
		leap_result_t r;
		mult = 32'd1;
		add  = 32'd0;
		if (!n_bits[31]) begin
			m = LCG_A;
			c = LCG_C;
			n = n_bits;
		end else begin
			m = LCG_A_INV;
			c = (32'd0 - LCG_C) * LCG_A_INV;
			n = 32'd0 - n_bits;
		end
		for (int i = 0; i < 32; i++) begin
			if (n[i]) begin
				add  = m * add + c;
				mult = m * mult;
			end
			c = m * c + c;
			m = m * m;
		end
		ns = s * mult + add;
		r.state = ns;
		r.fbits = ONE_PATTERN | (30'(ns >> 8) & MANT_FIELD);
		return r;
	endfunction

	initial begin
		mismatch_cnt    = 0;
		leaps_pending   = 0;
		jumps_taken     = 0;
		backward_jumps  = 0;
		zero_jumps      = 0;
		results_checked = 0;
	end

	// Sample both channels at the rising edge; results first, then new items
	always @(posedge clk) begin
		leap_result_t want;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (pending_leaps.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("[%0t] result with no jump outstanding: new_state %h float_bits %h",
							$realtime, new_state, float_bits);
				end else begin
					want = pending_leaps.pop_front();
					results_checked++;
					if (new_state !== want.state || float_bits !== want.fbits) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							if (new_state !== want.state)
								$display("[%0t] new_state: expected %h, got %h",
									$realtime, want.state, new_state);
							if (float_bits !== want.fbits)
								$display("[%0t] float_bits: expected %h, got %h",
									$realtime, want.fbits, float_bits);
						end
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				// Append at the tail of the queue
				pending_leaps.insert(pending_leaps.size(), lcg_leap(seed, step_count));
				jumps_taken++;
				if (step_count < 0)
					backward_jumps++;
				if (step_count == 0)
					zero_jumps++;
			end
			leaps_pending = pending_leaps.size();
		end
	end

endmodule

FILE: dv/lcg_jump_ahead_tb.sv
// Testbench top for the LCG jump-ahead block: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module lcg_jump_ahead_tb;
	import lja_pkg::*;

	localparam int RANDOM_JUMPS  = 780;
	localparam int LIMIT_CYCLES  = 2000000;
	localparam int SETTLE_CYCLES = 400;
	localparam int DIRECTED_N    = 20;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic        [WORD_W-1:0] seed;
	logic signed [WORD_W-1:0] step_count;
	logic                     done;
	logic        [WORD_W-1:0] new_state;
	logic        [29:0]       float_bits;

	int mismatch_cnt, leaps_pending, jumps_taken, backward_jumps, zero_jumps, results_checked;
	int cycle_cnt;

	// Seed and step pairs: zero, unit and most extreme counts, edge seeds
	logic [31:0] dir_seed [DIRECTED_N] = '{
		32'h00000000, 32'hffffffff, 32'h12345678, 32'h12345678, 32'h00000000,
		32'hffffffff, 32'h00000000, 32'hffffffff, 32'hdeadbeef, 32'hdeadbeef,
		32'ha5a5a5a5, 32'h5a5a5a5a, 32'h00000000, 32'hffffffff, 32'h13579bdf,
		32'h2468ace0, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hfffffffe};
	logic [31:0] dir_step [DIRECTED_N] = '{
		32'h00000000, 32'h00000000, 32'h00000001, 32'hffffffff, 32'h00000001,
		32'h00000001, 32'hffffffff, 32'hffffffff, 32'h00000002, 32'hfffffffe,
		32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h00010000,
		32'hffff0000, 32'h55555555, 32'haaaaaaaa, 32'h40000000, 32'hc0000000};

	lcg_jump_ahead dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.seed       (seed),
		.step_count (step_count),
		.done       (done),
		.new_state  (new_state),
		.float_bits (float_bits)
	);

	lja_leap_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.seed            (seed),
		.step_count      (step_count),
		.done            (done),
		.new_state       (new_state),
		.float_bits      (float_bits),
		.mismatch_cnt    (mismatch_cnt),
		.leaps_pending   (leaps_pending),
		.jumps_taken     (jumps_taken),
		.backward_jumps  (backward_jumps),
		.zero_jumps      (zero_jumps),
		.results_checked (results_checked)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Run watchdog
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d jumps still outstanding",
				cycle_cnt, leaps_pending);
			$display("lcg_jump_ahead regression: fail");
			$finish;
		end
	end

	// Present one jump and hold it until the block takes it
	task automatic issue_jump(input logic [31:0] s, input logic [31:0] n);
		@(negedge clk);
		start      <= 1'b1;
		seed       <= s;
		step_count <= n;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Sender drops start and idles; k sets the length of the gap
	task automatic hold_off(input int k);
		@(negedge clk);
		start <= 1'b0;
		repeat (k - 1) @(negedge clk);
	endtask

	// Sender waits until every outstanding jump has returned
	task automatic drain_jumps();
		@(negedge clk);
		start <= 1'b0;
		while (leaps_pending != 0)
			@(negedge clk);
	endtask

	// Step counts of mixed shape: full range, short hops, single bits, masked
	function automatic logic [31:0] pick_step();
		logic [31:0] n;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 3)
			n = $urandom;
		else if (kind < 6)
			n = 32'($urandom_range(0, 40));
		else if (kind < 8)
			n = 32'd1 << $urandom_range(0, 31);
		else
			n = $urandom >> $urandom_range(0, 31);
		if (kind >= 3 && $urandom_range(0, 1) == 1)
			n = 32'd0 - n;
		return n;
	endfunction

	function automatic logic [31:0] pick_seed();
		int unsigned kind;
		kind = $urandom_range(0, 19);
		if (kind == 0)
			return 32'h00000000;
		else if (kind == 1)
			return 32'hffffffff;
		else
			return $urandom;
	endfunction

	// Stimulus
	initial begin
		start      = 1'b0;
		seed       = '0;
		step_count = '0;
		arst_n     = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed jumps, back to back
		for (int i = 0; i < DIRECTED_N; i++)
			issue_jump(dir_seed[i], dir_step[i]);
		drain_jumps();

		// Random jumps with random sender gaps and a drain halfway; a stretch runs with no gap but that drain
		for (int i = 0; i < RANDOM_JUMPS; i++) begin
			if (i == RANDOM_JUMPS / 2)
				drain_jumps();
			else if ((i < 300 || i >= 420) && $urandom_range(0, 99) < 32) begin
				if ($urandom_range(0, 9) == 0)
					hold_off($urandom_range(1, 340));
				else
					hold_off($urandom_range(1, 6));
			end
			issue_jump(pick_seed(), pick_step());
		end

		drain_jumps();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d jumps (%0d backward, %0d of zero steps), directed extremes and random",
			jumps_taken, backward_jumps, zero_jumps);
		$display("%0d results checked, %0d mismatches", results_checked, mismatch_cnt);
		if (mismatch_cnt == 0 && leaps_pending == 0)
			$display("lcg_jump_ahead regression: pass");
		else
			$display("lcg_jump_ahead regression: fail");
		$finish;
	end

endmodule
